[src/i2crtc_pkg.sv]
// ----------------------------------------------------------------------------
// i2crtc_pkg: shared types and helpers for the I2C RTC register master
// Item layouts, bus phase and element codes, register reset values, and the
// BCD conversion helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crtc_pkg;

  localparam int unsigned CfgAddrWidth = 4;

  localparam logic [6:0] DevAddrReset  = 7'd104;
  localparam logic [7:0] HourRegReset  = 8'd2;
  localparam logic [7:0] HourMaskReset = 8'h3f;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_WRITE_RAW  = 3'd1,
    OP_WRITE_TIME = 3'd2,
    OP_READ_TIME  = 3'd3,
    OP_READ_RAW   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S0   = 4'd1,
    PH_S1   = 4'd2,
    PH_S2   = 4'd3,
    PH_TL   = 4'd4,
    PH_TH   = 4'd5,
    PH_AL   = 4'd6,
    PH_AH   = 4'd7,
    PH_RL   = 4'd8,
    PH_RH   = 4'd9,
    PH_NL   = 4'd10,
    PH_NH   = 4'd11,
    PH_R0   = 4'd12,
    PH_P0   = 4'd13,
    PH_P1   = 4'd14,
    PH_P2   = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    EL_TXW    = 3'd0,
    EL_TXREG  = 3'd1,
    EL_TXDATA = 3'd2,
    EL_TXR    = 3'd3,
    EL_RSTART = 3'd4,
    EL_RX     = 3'd5,
    EL_STOP   = 3'd6
  } elem_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] reg_address;
    logic [7:0] data_value;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic [7:0] read_value;
  } res_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] hour_reg;
    logic [7:0] hour_mask;
  } cfg_t;

  // Bus element to run at a given step of a transaction.
  function automatic elem_t elem_at(input logic [2:0] cmd, input logic [2:0] stage);
    elem_t e;
    e = EL_STOP;
    case (cmd)
      OP_WRITE_RAW, OP_WRITE_TIME: begin
        case (stage)
          3'd0:    e = EL_TXW;
          3'd1:    e = EL_TXREG;
          3'd2:    e = EL_TXDATA;
          default: e = EL_STOP;
        endcase
      end
      OP_READ_TIME: begin
        case (stage)
          3'd0:    e = EL_TXW;
          3'd1:    e = EL_TXREG;
          3'd2:    e = EL_RSTART;
          3'd3:    e = EL_TXR;
          3'd4:    e = EL_RX;
          default: e = EL_STOP;
        endcase
      end
      OP_READ_RAW: begin
        case (stage)
          3'd0:    e = EL_TXR;
          3'd1:    e = EL_RX;
          default: e = EL_STOP;
        endcase
      end
      default: e = EL_STOP;
    endcase
    return e;
  endfunction

  // Binary modulo 100 to two BCD digits; tens by reciprocal multiply (205/2048).
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [6:0]  m;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    if (v >= 8'd200) begin
      m = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      m = 7'(v - 8'd100);
    end else begin
      m = v[6:0];
    end
    prod = 15'(m) * 15'd205;
    tens = prod[14:11];
    ones = 4'(m - 7'({3'b000, tens} * 7'd10));
    return {tens, ones};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return 8'({4'b0000, v[7:4]} * 8'd10 + {4'b0000, v[3:0]});
  endfunction

endpackage

`default_nettype wire

[src/i2crtc_cfg.sv]
// ----------------------------------------------------------------------------
// i2crtc_cfg: configuration registers
// APB-style slave holding device address, hour register index and hour mask.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crtc_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [i2crtc_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output i2crtc_pkg::cfg_t                        cfg
);

  localparam logic [1:0] RegDevAddr  = 2'd0;
  localparam logic [1:0] RegHourReg  = 2'd1;
  localparam logic [1:0] RegHourMask = 2'd2;

  logic [1:0] index;
  logic       wr_en;

  assign index  = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_addr  <= i2crtc_pkg::DevAddrReset;
      cfg.hour_reg  <= i2crtc_pkg::HourRegReset;
      cfg.hour_mask <= i2crtc_pkg::HourMaskReset;
    end else if (wr_en) begin
      unique case (index)
        RegDevAddr:  cfg.dev_addr  <= pwdata[6:0];
        RegHourReg:  cfg.hour_reg  <= pwdata[7:0];
        RegHourMask: cfg.hour_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      RegDevAddr:  prdata = {25'd0, cfg.dev_addr};
      RegHourReg:  prdata = {24'd0, cfg.hour_reg};
      RegHourMask: prdata = {24'd0, cfg.hour_mask};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[src/i2crtc_engine.sv]
// ----------------------------------------------------------------------------
// i2crtc_engine: bus phase sequencer
// Holds the transaction state and advances it by one item per step, giving
// the line levels and completion result for that item.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crtc_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire i2crtc_pkg::cmd_t  item,
  input  wire i2crtc_pkg::cfg_t  cfg,
  output i2crtc_pkg::res_t       result
);

  i2crtc_pkg::phase_t phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] latched_command, latched_command_next;
  logic [7:0] latched_register, latched_register_next;
  logic [7:0] latched_data, latched_data_next;
  logic       ack_seen, ack_seen_next;
  logic [2:0] stage, stage_next;
  logic       last_scl, last_scl_next;
  logic       last_sda, last_sda_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= i2crtc_pkg::PH_IDLE;
      bit_count        <= '0;
      shift_byte       <= '0;
      latched_command  <= '0;
      latched_register <= '0;
      latched_data     <= '0;
      ack_seen         <= 1'b0;
      stage            <= '0;
      last_scl         <= 1'b1;
      last_sda         <= 1'b1;
    end else if (step) begin
      phase            <= phase_next;
      bit_count        <= bit_count_next;
      shift_byte       <= shift_byte_next;
      latched_command  <= latched_command_next;
      latched_register <= latched_register_next;
      latched_data     <= latched_data_next;
      ack_seen         <= ack_seen_next;
      stage            <= stage_next;
      last_scl         <= last_scl_next;
      last_sda         <= last_sda_next;
    end
  end

  always_comb begin
    logic               busy;
    logic               take_next;
    logic               scl_o;
    logic               sda_o;
    logic               done;
    logic               stat;
    logic [7:0]         val;
    i2crtc_pkg::elem_t  el;

    phase_next            = phase;
    bit_count_next        = bit_count;
    shift_byte_next       = shift_byte;
    latched_command_next  = latched_command;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    ack_seen_next         = ack_seen;
    stage_next            = stage;
    last_scl_next         = last_scl;
    last_sda_next         = last_sda;
    take_next             = 1'b0;
    done                  = 1'b0;
    stat                  = 1'b0;
    val                   = 8'd0;
    busy                  = (phase != i2crtc_pkg::PH_IDLE);
    scl_o                 = last_scl;
    sda_o                 = last_sda;

    case (item.op) inside
      i2crtc_pkg::OP_TICK: begin
        unique case (phase)
          i2crtc_pkg::PH_S0: begin
            scl_o = 1'b1; sda_o = 1'b1; phase_next = i2crtc_pkg::PH_S1;
          end
          i2crtc_pkg::PH_S1: begin
            scl_o = 1'b1; sda_o = 1'b0; phase_next = i2crtc_pkg::PH_S2;
          end
          i2crtc_pkg::PH_S2: begin
            scl_o = 1'b0; sda_o = 1'b0; take_next = 1'b1;
          end
          i2crtc_pkg::PH_TL: begin
            scl_o = 1'b0; sda_o = shift_byte[7]; phase_next = i2crtc_pkg::PH_TH;
          end
          i2crtc_pkg::PH_TH: begin
            scl_o = 1'b1; sda_o = shift_byte[7];
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = 4'(bit_count + 4'd1);
            phase_next = (bit_count_next >= 4'd8) ? i2crtc_pkg::PH_AL : i2crtc_pkg::PH_TL;
          end
          i2crtc_pkg::PH_AL: begin
            scl_o = 1'b0; sda_o = 1'b1; phase_next = i2crtc_pkg::PH_AH;
          end
          i2crtc_pkg::PH_AH: begin
            scl_o = 1'b1; sda_o = 1'b1;
            ack_seen_next = !item.sda_in;
            // abort with a STOP on NACK
            if (!item.sda_in) begin
              take_next = 1'b1;
            end else begin
              phase_next = i2crtc_pkg::PH_P0;
            end
          end
          i2crtc_pkg::PH_RL: begin
            scl_o = 1'b0; sda_o = 1'b1; phase_next = i2crtc_pkg::PH_RH;
          end
          i2crtc_pkg::PH_RH: begin
            scl_o = 1'b1; sda_o = 1'b1;
            shift_byte_next = {shift_byte[6:0], item.sda_in};
            bit_count_next  = 4'(bit_count + 4'd1);
            phase_next = (bit_count_next >= 4'd8) ? i2crtc_pkg::PH_NL : i2crtc_pkg::PH_RL;
          end
          i2crtc_pkg::PH_NL: begin
            scl_o = 1'b0; sda_o = 1'b1; phase_next = i2crtc_pkg::PH_NH;
          end
          i2crtc_pkg::PH_NH: begin
            scl_o = 1'b1; sda_o = 1'b1; take_next = 1'b1;
          end
          i2crtc_pkg::PH_R0: begin
            scl_o = 1'b0; sda_o = 1'b1; phase_next = i2crtc_pkg::PH_S0;
          end
          i2crtc_pkg::PH_P0: begin
            scl_o = 1'b0; sda_o = 1'b0; phase_next = i2crtc_pkg::PH_P1;
          end
          i2crtc_pkg::PH_P1: begin
            scl_o = 1'b1; sda_o = 1'b0; phase_next = i2crtc_pkg::PH_P2;
          end
          i2crtc_pkg::PH_P2: begin
            scl_o = 1'b1; sda_o = 1'b1; done = 1'b1;
            stat  = !ack_seen;
            if (ack_seen && (latched_command == i2crtc_pkg::OP_READ_TIME)) begin
              val = i2crtc_pkg::from_bcd((latched_register == cfg.hour_reg) ?
                                         (shift_byte & cfg.hour_mask) : shift_byte);
            end else if (ack_seen && (latched_command == i2crtc_pkg::OP_READ_RAW)) begin
              val = shift_byte;
            end
            phase_next = i2crtc_pkg::PH_IDLE;
          end
          i2crtc_pkg::PH_IDLE: begin
            scl_o = 1'b1; sda_o = 1'b1;
          end
        endcase
        last_scl_next = scl_o;
        last_sda_next = sda_o;
      end
      i2crtc_pkg::OP_WRITE_RAW, i2crtc_pkg::OP_WRITE_TIME,
      i2crtc_pkg::OP_READ_TIME, i2crtc_pkg::OP_READ_RAW: begin
        if (!busy) begin
          latched_command_next  = item.op;
          latched_register_next = item.reg_address;
          latched_data_next     = (item.op == i2crtc_pkg::OP_WRITE_TIME) ?
                                  i2crtc_pkg::to_bcd(item.data_value) : item.data_value;
          stage_next      = '0;
          bit_count_next  = '0;
          shift_byte_next = '0;
          ack_seen_next   = 1'b0;
          phase_next      = i2crtc_pkg::PH_S0;
          last_scl_next   = 1'b1;
          last_sda_next   = 1'b1;
          scl_o = 1'b1; sda_o = 1'b1;
        end
      end
      default: begin
        if (!busy) begin
          last_scl_next = 1'b1;
          last_sda_next = 1'b1;
          scl_o = 1'b1; sda_o = 1'b1;
        end
      end
    endcase

    // load the next bus element of the transaction
    el = i2crtc_pkg::elem_at(latched_command, stage);
    if (take_next) begin
      if (stage < 3'd5) begin
        stage_next = 3'(stage + 3'd1);
      end
      bit_count_next = '0;
      case (el)
        i2crtc_pkg::EL_TXW: begin
          shift_byte_next = {cfg.dev_addr, 1'b0};
          phase_next = i2crtc_pkg::PH_TL;
        end
        i2crtc_pkg::EL_TXR: begin
          shift_byte_next = {cfg.dev_addr, 1'b1};
          phase_next = i2crtc_pkg::PH_TL;
        end
        i2crtc_pkg::EL_TXREG: begin
          shift_byte_next = latched_register;
          phase_next = i2crtc_pkg::PH_TL;
        end
        i2crtc_pkg::EL_TXDATA: begin
          shift_byte_next = latched_data;
          phase_next = i2crtc_pkg::PH_TL;
        end
        i2crtc_pkg::EL_RSTART: phase_next = i2crtc_pkg::PH_R0;
        i2crtc_pkg::EL_RX: begin
          shift_byte_next = '0;
          phase_next = i2crtc_pkg::PH_RL;
        end
        default: phase_next = i2crtc_pkg::PH_P0;
      endcase
    end

    result.scl_out    = scl_o;
    result.sda_out    = sda_o;
    result.busy_res   = (phase_next != i2crtc_pkg::PH_IDLE);
    result.done_res   = done;
    result.status     = stat;
    result.read_value = val;
  end

endmodule

`default_nettype wire

[src/i2c_rtc_register_master_unit.sv]
// ----------------------------------------------------------------------------
// i2c_rtc_register_master_unit: I2C register master for a real-time clock
// Commands start register transactions; tick items step the bus one phase.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   cmd     | in        | cmd_valid / cmd_stall  | op, reg_address, data_value, sda_in
//   res     | out       | res_valid / res_stall  | scl_out, sda_out, busy_res, done_res,
//           |           |                        | status, read_value
//   apb     | in        | psel/penable, pready=1 | device_address, hour_register, hour_mask
//
// One item per cycle sustained while res is not stalled; each accepted item
// passes through the input register, then the sequencer step into the result
// register, where its result is valid.
// The sequencer steps only when the result register is free or being taken.
// A stall on res holds the result and, one stage back, stalls cmd.
// Synchronous reset returns the bus to idle with both lines released.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rtc_register_master_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_stall,
  input  wire i2crtc_pkg::cmd_t                   cmd,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output i2crtc_pkg::res_t                        res,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [i2crtc_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);

  i2crtc_pkg::cfg_t cfg;
  i2crtc_pkg::cmd_t item;
  i2crtc_pkg::res_t step_res;
  logic             item_valid;
  logic             advance;
  logic             step;
  logic             cmd_accept;

  assign advance    = !res_valid || !res_stall;
  assign step       = item_valid && advance;
  assign cmd_stall  = item_valid && !advance;
  assign cmd_accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd_accept) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      item <= cmd;
    end
    if (step) begin
      res <= step_res;
    end
  end

  i2crtc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2crtc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (step_res)
  );

endmodule

`default_nettype wire

[src/i2crtc_chk.sv]
// ----------------------------------------------------------------------------
// i2crtc_chk: port checker for the I2C RTC register master
// Watches the result channel for consistency of completion fields.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crtc_chk (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             res_valid,
  input wire logic             res_stall,
  input wire i2crtc_pkg::res_t res
);

  // a completing item leaves the bus idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done item still reports busy");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> res.done_res)
    else $error("status raised without done");

  // read data only on a clean completion
  a_value_on_success: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.read_value != 8'd0) |-> res.done_res && !res.status)
    else $error("read value outside a successful completion");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

endmodule

bind i2c_rtc_register_master_unit i2crtc_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

[test/i2c_rtc_register_master_unit_tb.sv]
// ----------------------------------------------------------------------------
// i2c_rtc_register_master_unit_tb: self-checking bench for the I2C RTC master
// A line-level model of the bus sequencer tracks every accepted item and
// predicts the SCL/SDA levels, busy, done, status and read byte of its result.
// Stimulus is mostly complete transactions with a plausible slave: ACKs
// mostly given and random read bits. Commands given while busy, unused op
// codes and NACK aborts are mixed in. Phases vary the register settings and
// the idling on both channels. One phase holds off the result side long
// enough for the block to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rtc_register_master_unit_tb;
  import i2crtc_pkg::*;

  localparam logic [CfgAddrWidth-1:0] ADDR_DEV_ADDR  = 4'd0;
  localparam logic [CfgAddrWidth-1:0] ADDR_HOUR_REG  = 4'd4;
  localparam logic [CfgAddrWidth-1:0] ADDR_HOUR_MASK = 4'd8;

  // op codes the block treats as no operation
  localparam int OP_UNUSED_FIRST = 5;
  localparam int OP_UNUSED_LAST  = 7;

  localparam int PHASE_ITEMS = 330;
  localparam int HOLD_CYCLES = 300;

  // model of the bus sequencer plus the queue of results it predicts
  class rtc_bus_tracker;
    logic [6:0] dev_addr;
    logic [7:0] hour_reg;
    logic [7:0] hour_mask;
    phase_t     phase;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [2:0] cur_cmd;
    logic [7:0] cur_reg;
    logic [7:0] cur_data;
    logic       acked;
    logic [2:0] stage;
    logic       line_scl;
    logic       line_sda;
    res_t       expected_lines[$];
    int         errors;

    function new();
      dev_addr  = DevAddrReset;
      hour_reg  = HourRegReset;
      hour_mask = HourMaskReset;
      phase     = PH_IDLE;
      bit_cnt   = '0;
      shreg     = '0;
      cur_cmd   = '0;
      cur_reg   = '0;
      cur_data  = '0;
      acked     = 1'b0;
      stage     = '0;
      line_scl  = 1'b1;
      line_sda  = 1'b1;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgAddrWidth-1:0] addr, logic [31:0] value);
      case (addr)
        ADDR_DEV_ADDR:  dev_addr  = value[6:0];
        ADDR_HOUR_REG:  hour_reg  = value[7:0];
        ADDR_HOUR_MASK: hour_mask = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] bin_to_bcd(logic [7:0] v);
      int m;
      m = v % 100;
      return 8'(((m / 10) << 4) | (m % 10));
    endfunction

    function logic [7:0] bcd_to_bin(logic [7:0] v);
      return 8'(int'(v[7:4]) * 10 + int'(v[3:0]));
    endfunction

    function elem_t elem_for(logic [2:0] cmd, logic [2:0] st);
      elem_t e;
      e = EL_STOP;
      if (cmd == OP_WRITE_RAW || cmd == OP_WRITE_TIME) begin
        if (st == 3'd0) e = EL_TXW;
        else if (st == 3'd1) e = EL_TXREG;
        else if (st == 3'd2) e = EL_TXDATA;
      end else if (cmd == OP_READ_TIME) begin
        if (st == 3'd0) e = EL_TXW;
        else if (st == 3'd1) e = EL_TXREG;
        else if (st == 3'd2) e = EL_RSTART;
        else if (st == 3'd3) e = EL_TXR;
        else if (st == 3'd4) e = EL_RX;
      end else if (cmd == OP_READ_RAW) begin
        if (st == 3'd0) e = EL_TXR;
        else if (st == 3'd1) e = EL_RX;
      end
      return e;
    endfunction

    // start the next element of the current transaction
    function void advance();
      elem_t e;
      e = elem_for(cur_cmd, stage);
      if (stage < 3'd5) stage++;
      bit_cnt = '0;
      case (e)
        EL_TXW: begin
          shreg = {dev_addr, 1'b0};
          phase = PH_TL;
        end
        EL_TXR: begin
          shreg = {dev_addr, 1'b1};
          phase = PH_TL;
        end
        EL_TXREG: begin
          shreg = cur_reg;
          phase = PH_TL;
        end
        EL_TXDATA: begin
          shreg = cur_data;
          phase = PH_TL;
        end
        EL_RSTART: phase = PH_R0;
        EL_RX: begin
          shreg = '0;
          phase = PH_RL;
        end
        default: phase = PH_P0;
      endcase
    endfunction

    function void take_command(cmd_t c);
      res_t       r;
      logic       busy;
      logic       bit7;
      logic [7:0] v;
      r = '0;
      busy = (phase != PH_IDLE);
      if (c.op != OP_TICK) begin
        if (!busy && c.op <= OP_READ_RAW) begin
          cur_cmd  = c.op;
          cur_reg  = c.reg_address;
          cur_data = (c.op == OP_WRITE_TIME) ? bin_to_bcd(c.data_value) : c.data_value;
          stage    = '0;
          bit_cnt  = '0;
          shreg    = '0;
          acked    = 1'b0;
          phase    = PH_S0;
          line_scl = 1'b1;
          line_sda = 1'b1;
        end else if (!busy) begin
          line_scl = 1'b1;
          line_sda = 1'b1;
        end
        // ignored commands repeat the last driven levels
        r.scl_out = line_scl;
        r.sda_out = line_sda;
      end else begin
        bit7 = shreg[7];
        case (phase)
          PH_S0: begin
            r.scl_out = 1'b1; r.sda_out = 1'b1; phase = PH_S1;
          end
          PH_S1: begin
            r.scl_out = 1'b1; r.sda_out = 1'b0; phase = PH_S2;
          end
          PH_S2: begin
            r.scl_out = 1'b0; r.sda_out = 1'b0; advance();
          end
          PH_TL: begin
            r.scl_out = 1'b0; r.sda_out = bit7; phase = PH_TH;
          end
          PH_TH: begin
            r.scl_out = 1'b1; r.sda_out = bit7;
            shreg = shreg << 1;
            bit_cnt++;
            if (bit_cnt >= 4'd8) phase = PH_AL;
            else phase = PH_TL;
          end
          PH_AL: begin
            r.scl_out = 1'b0; r.sda_out = 1'b1; phase = PH_AH;
          end
          PH_AH: begin
            r.scl_out = 1'b1; r.sda_out = 1'b1;
            acked = !c.sda_in;
            if (acked) advance();
            else phase = PH_P0;
          end
          PH_RL: begin
            r.scl_out = 1'b0; r.sda_out = 1'b1; phase = PH_RH;
          end
          PH_RH: begin
            r.scl_out = 1'b1; r.sda_out = 1'b1;
            shreg = {shreg[6:0], c.sda_in};
            bit_cnt++;
            if (bit_cnt >= 4'd8) phase = PH_NL;
            else phase = PH_RL;
          end
          PH_NL: begin
            r.scl_out = 1'b0; r.sda_out = 1'b1; phase = PH_NH;
          end
          PH_NH: begin
            r.scl_out = 1'b1; r.sda_out = 1'b1; advance();
          end
          PH_R0: begin
            r.scl_out = 1'b0; r.sda_out = 1'b1; phase = PH_S0;
          end
          PH_P0: begin
            r.scl_out = 1'b0; r.sda_out = 1'b0; phase = PH_P1;
          end
          PH_P1: begin
            r.scl_out = 1'b1; r.sda_out = 1'b0; phase = PH_P2;
          end
          PH_P2: begin
            r.scl_out  = 1'b1;
            r.sda_out  = 1'b1;
            r.done_res = 1'b1;
            r.status   = !acked;
            if (acked && (cur_cmd == OP_READ_TIME || cur_cmd == OP_READ_RAW)) begin
              v = shreg;
              if (cur_cmd == OP_READ_TIME) begin
                if (cur_reg == hour_reg) v = v & hour_mask;
                v = bcd_to_bin(v);
              end
              r.read_value = v;
            end
            phase = PH_IDLE;
          end
          default: begin
            r.scl_out = 1'b1; r.sda_out = 1'b1; phase = PH_IDLE;
          end
        endcase
        line_scl = r.scl_out;
        line_sda = r.sda_out;
      end
      r.busy_res = (phase != PH_IDLE);
      expected_lines.push_back(r);
    endfunction

    // four-state compare so an unknown output counts as a mismatch
    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(res_t got);
      res_t want;
      if (expected_lines.size() == 0) begin
        $error("result with no item pending: %h", got);
        errors++;
        return;
      end
      want = expected_lines.pop_front();
      field_check("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      field_check("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      field_check("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      field_check("done_res", 8'(want.done_res), 8'(got.done_res));
      field_check("status", 8'(want.status), 8'(got.status));
      field_check("read_value", want.read_value, got.read_value);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rtc_bus_tracker tracker = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  i2c_rtc_register_master_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: random stall, or a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.compare_result(res);
  end

  function automatic cmd_t tick_item();
    cmd_t c;
    c.op          = OP_TICK;
    c.reg_address = 8'($urandom);
    c.data_value  = 8'($urandom);
    // a cooperative slave acks most bytes
    if (tracker.phase == PH_AH) c.sda_in = ($urandom_range(99) < 8);
    else c.sda_in = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic cmd_t pick_item();
    cmd_t c;
    int   roll;
    int   pick;
    c = tick_item();
    roll = $urandom_range(99);
    if (tracker.phase == PH_IDLE) begin
      if (roll < 80) begin
        c.op = 3'($urandom_range(int'(OP_READ_RAW), int'(OP_WRITE_RAW)));
        if (c.op == OP_READ_TIME && $urandom_range(99) < 40) c.reg_address = tracker.hour_reg;
        pick = $urandom_range(9);
        if (pick == 0) c.data_value = 8'd0;
        else if (pick == 1) c.data_value = 8'd255;
        else if (pick == 2) c.data_value = 8'($urandom_range(101, 98));
      end else if (roll < 90) begin
        c.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end
    end else if (roll < 4) begin
      c.op = 3'($urandom_range(OP_UNUSED_LAST, int'(OP_WRITE_RAW)));
    end
    return c;
  endfunction

  // offer one item, with random gaps first, and note it once taken
  task automatic send_item(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    tracker.take_command(c);
  endtask

  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (tracker.expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CfgAddrWidth-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(addr, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [6:0] dev, input logic [7:0] hreg, input logic [7:0] hmask);
    apb_write(ADDR_DEV_ADDR, 32'(dev));
    apb_write(ADDR_HOUR_REG, 32'(hreg));
    apb_write(ADDR_HOUR_MASK, 32'(hmask));
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input bit with_hold);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 30) hold_req = 1'b1;
      send_item(pick_item());
    end
    // finish the open transaction so the next settings apply to a quiet bus
    while (tracker.phase != PH_IDLE) send_item(tick_item());
    settle();
  endtask

  task automatic directed_items();
    cmd_t c;
    idle_pct  = 30;
    stall_pct = 30;
    c = '{op: OP_TICK, reg_address: 8'd0, data_value: 8'd0, sda_in: 1'b0};
    send_item(c);
    c = '{op: 3'(OP_UNUSED_LAST), reg_address: 8'd255, data_value: 8'd255, sda_in: 1'b1};
    send_item(c);
    c = '{op: 3'(OP_UNUSED_FIRST), reg_address: 8'd0, data_value: 8'd0, sda_in: 1'b0};
    send_item(c);
    c = '{op: OP_WRITE_TIME, reg_address: 8'd255, data_value: 8'd255, sda_in: 1'b0};
    send_item(c);
    // command while busy: ignored
    c = '{op: OP_READ_RAW, reg_address: 8'd0, data_value: 8'd0, sda_in: 1'b1};
    send_item(c);
    // slave never acks: abort after the address byte
    c = '{op: OP_TICK, reg_address: 8'd255, data_value: 8'd0, sda_in: 1'b1};
    while (tracker.phase != PH_IDLE) send_item(c);
    settle();
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    res_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    directed_items();

    set_regs(7'd127, 8'd255, 8'd255);
    run_phase(PHASE_ITEMS, 0, 0, 1'b0);

    set_regs(7'd0, 8'd0, 8'd0);
    run_phase(PHASE_ITEMS, 78, 0, 1'b0);

    set_regs(7'($urandom), 8'($urandom_range(3)), 8'($urandom));
    run_phase(PHASE_ITEMS, 0, 78, 1'b0);

    set_regs(DevAddrReset, HourRegReset, HourMaskReset);
    run_phase(PHASE_ITEMS, 18, 18, 1'b0);

    set_regs(7'($urandom), 8'($urandom_range(7)), 8'($urandom));
    run_phase(PHASE_ITEMS, 0, 0, 1'b1);

    // catch any stray results after the last one expected
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/i2crtc_pkg.sv
src/i2crtc_cfg.sv
src/i2crtc_engine.sv
src/i2c_rtc_register_master_unit.sv
src/i2crtc_chk.sv
test/i2c_rtc_register_master_unit_tb.sv
